>>> hw/rtl/bmcs_pkg.sv
// Shared types and constants for the ball motion and collision step core.
package bmcs_pkg;
    localparam int MaxBalls = 16;
    localparam int IdxW     = 4;
    localparam int CntW     = 5;
    localparam int PosW     = 16;
    localparam int RadW     = 12;
    localparam int FieldW   = 15;

    localparam logic [1:0] CfgBallCount   = 2'd0;
    localparam logic [1:0] CfgFieldWidth  = 2'd1;
    localparam logic [1:0] CfgFieldHeight = 2'd2;

    localparam logic CmdWrite = 1'b0;
    localparam logic CmdStep  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             wr_entry;   // load the input entry
        logic             load_ball;  // latch ball i and its trial position
        logic             cmp_pair;   // compare ball i against ball j
        logic             resolve;    // write back ball i, negate hit
        logic             wall;       // wall bounce for ball i
        logic             emit;       // put entry i on the result ports
        logic             emit_last;
        logic [IdxW-1:0]  i;
        logic [IdxW-1:0]  j;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;  // a pair within reach was found for ball i
    } t_dp_sts;

    function automatic logic signed [PosW-1:0] sat16(input logic signed [PosW:0] v);
        if (v > 17'sd32767)       return 16'sh7fff;
        else if (v < -17'sd32768) return 16'sh8000;
        else                      return v[PosW-1:0];
    endfunction

    function automatic logic signed [PosW-1:0] neg16(input logic signed [PosW-1:0] v);
        return sat16(-{v[PosW-1], v});
    endfunction
endpackage

>>> hw/rtl/bmcs_datapath.sv
// Ball table storage and the collision, move and bounce arithmetic.
module bmcs_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bmcs_pkg::t_dp_cmd                   i_cmd,
    output bmcs_pkg::t_dp_sts                   o_sts,
    input  logic [bmcs_pkg::IdxW-1:0]           i_ball_index,
    input  logic signed [bmcs_pkg::PosW-1:0]    i_pos_x,
    input  logic signed [bmcs_pkg::PosW-1:0]    i_pos_y,
    input  logic signed [bmcs_pkg::PosW-1:0]    i_vel_x,
    input  logic signed [bmcs_pkg::PosW-1:0]    i_vel_y,
    input  logic [bmcs_pkg::RadW-1:0]           i_radius,
    input  logic [bmcs_pkg::FieldW-1:0]         i_field_width,
    input  logic [bmcs_pkg::FieldW-1:0]         i_field_height,
    output logic                                o_valid,
    output logic [bmcs_pkg::IdxW-1:0]           o_ball_index_res,
    output logic signed [bmcs_pkg::PosW-1:0]    o_pos_x_res,
    output logic signed [bmcs_pkg::PosW-1:0]    o_pos_y_res,
    output logic signed [bmcs_pkg::PosW-1:0]    o_vel_x_res,
    output logic signed [bmcs_pkg::PosW-1:0]    o_vel_y_res,
    output logic                                o_last
);
    // The stores hold 16 entries read at fixed-role ports; kept in flip-flops.
    logic signed [bmcs_pkg::PosW-1:0] r_px [bmcs_pkg::MaxBalls];
    logic signed [bmcs_pkg::PosW-1:0] r_py [bmcs_pkg::MaxBalls];
    logic signed [bmcs_pkg::PosW-1:0] r_vx [bmcs_pkg::MaxBalls];
    logic signed [bmcs_pkg::PosW-1:0] r_vy [bmcs_pkg::MaxBalls];
    logic [bmcs_pkg::RadW-1:0]        r_rad [bmcs_pkg::MaxBalls];

    logic signed [bmcs_pkg::PosW-1:0] r_nx, r_ny;
    logic [bmcs_pkg::RadW-1:0]        r_ri;
    logic                             r_hit;
    logic [bmcs_pkg::IdxW-1:0]        r_hit_idx;

    logic signed [bmcs_pkg::PosW:0]   dx, dy;
    logic [2*bmcs_pkg::PosW:0]        d2;
    logic [bmcs_pkg::RadW:0]          rs;
    logic [2*bmcs_pkg::RadW+1:0]      lim;
    logic signed [bmcs_pkg::PosW-1:0] px_i, py_i, vx_i, vy_i;
    logic signed [bmcs_pkg::PosW-1:0] vx_neg, vy_neg;

    always_comb begin
        dx  = {r_nx[bmcs_pkg::PosW-1], r_nx} - {r_px[i_cmd.j][bmcs_pkg::PosW-1], r_px[i_cmd.j]};
        dy  = {r_ny[bmcs_pkg::PosW-1], r_ny} - {r_py[i_cmd.j][bmcs_pkg::PosW-1], r_py[i_cmd.j]};
        d2  = {1'b0, 32'(dx * dx)} + {1'b0, 32'(dy * dy)};
        rs  = {1'b0, r_ri} + {1'b0, r_rad[i_cmd.j]};
        lim = rs * rs;
        px_i = r_px[i_cmd.i];
        py_i = r_py[i_cmd.i];
        vx_i = r_vx[i_cmd.i];
        vy_i = r_vy[i_cmd.i];
        vx_neg = bmcs_pkg::neg16(vx_i);
        vy_neg = bmcs_pkg::neg16(vy_i);
    end

    assign o_sts.hit = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            o_last  <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            o_last  <= i_cmd.emit & i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            r_px[i_ball_index]  <= i_pos_x;
            r_py[i_ball_index]  <= i_pos_y;
            r_vx[i_ball_index]  <= i_vel_x;
            r_vy[i_ball_index]  <= i_vel_y;
            r_rad[i_ball_index] <= i_radius;
        end
        if (i_cmd.load_ball) begin
            r_nx  <= bmcs_pkg::sat16({px_i[15], px_i} + {vx_i[15], vx_i});
            r_ny  <= bmcs_pkg::sat16({py_i[15], py_i} + {vy_i[15], vy_i});
            r_ri  <= r_rad[i_cmd.i];
            r_hit <= 1'b0;
        end
        if (i_cmd.cmp_pair && !r_hit && (i_cmd.j != i_cmd.i)
            && (d2 <= {7'd0, lim})) begin
            r_hit     <= 1'b1;
            r_hit_idx <= i_cmd.j;
        end
        if (i_cmd.resolve) begin
            if (!r_hit) begin
                r_px[i_cmd.i] <= r_nx;
                r_py[i_cmd.i] <= r_ny;
            end else begin
                r_vx[i_cmd.i] <= vx_neg;
                r_vy[i_cmd.i] <= vy_neg;
                r_vx[r_hit_idx] <= bmcs_pkg::neg16(r_vx[r_hit_idx]);
                r_vy[r_hit_idx] <= bmcs_pkg::neg16(r_vy[r_hit_idx]);
            end
        end
        if (i_cmd.wall) begin
            if (px_i > $signed({1'b0, i_field_width}) || px_i[15])
                r_vx[i_cmd.i] <= vx_neg;
            if (py_i > $signed({1'b0, i_field_height}) || py_i[15])
                r_vy[i_cmd.i] <= vy_neg;
        end
        if (i_cmd.emit) begin
            o_ball_index_res <= i_cmd.i;
            o_pos_x_res      <= px_i;
            o_pos_y_res      <= py_i;
            o_vel_x_res      <= vx_i;
            o_vel_y_res      <= vy_i;
        end
    end
endmodule

>>> hw/rtl/bmcs_ctrl.sv
// Sequencer for write and step commands of the ball core.
module bmcs_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_command,
    input  logic [bmcs_pkg::CntW-1:0]    i_count,
    output logic                         o_busy,
    output bmcs_pkg::t_dp_cmd            o_cmd
);
    localparam logic [2:0] StIdle    = 3'd0;
    localparam logic [2:0] StLoad    = 3'd1;
    localparam logic [2:0] StCmp     = 3'd2;
    localparam logic [2:0] StResolve = 3'd3;
    localparam logic [2:0] StWall    = 3'd4;
    localparam logic [2:0] StEmit    = 3'd5;

    logic [2:0]                r_state, n_state;
    logic [bmcs_pkg::IdxW-1:0] r_i, n_i, r_j, n_j;
    logic [bmcs_pkg::CntW-1:0] r_cnt, n_cnt;
    logic [bmcs_pkg::CntW-1:0] cnt_sat;
    logic                      i_end, j_end;

    assign cnt_sat = (i_count > bmcs_pkg::CntW'(bmcs_pkg::MaxBalls))
                     ? bmcs_pkg::CntW'(bmcs_pkg::MaxBalls) : i_count;
    assign i_end  = ({1'b0, r_i} == r_cnt - 5'd1);
    assign j_end  = ({1'b0, r_j} == r_cnt - 5'd1);
    assign o_busy = (r_state != StIdle);

    always_comb begin
        n_state = r_state;
        n_i = r_i;
        n_j = r_j;
        n_cnt = r_cnt;
        o_cmd = '0;
        o_cmd.i = r_i;
        o_cmd.j = r_j;
        case (r_state)
            StIdle: begin
                o_cmd.wr_entry = i_start && (i_command == bmcs_pkg::CmdWrite);
                if (i_start && i_command == bmcs_pkg::CmdStep && cnt_sat != '0) begin
                    n_cnt = cnt_sat;
                    n_i = '0;
                    n_state = StLoad;
                end
            end
            StLoad: begin
                o_cmd.load_ball = 1'b1;
                n_j = '0;
                n_state = StCmp;
            end
            StCmp: begin
                o_cmd.cmp_pair = 1'b1;
                n_j = r_j + 4'd1;
                if (j_end) n_state = StResolve;
            end
            StResolve: begin
                o_cmd.resolve = 1'b1;
                n_state = StWall;
            end
            StWall: begin
                o_cmd.wall = 1'b1;
                n_i = r_i + 4'd1;
                if (i_end) begin
                    n_i = '0;
                    n_state = StEmit;
                end else begin
                    n_state = StLoad;
                end
            end
            StEmit: begin
                o_cmd.emit = 1'b1;
                o_cmd.emit_last = i_end;
                n_i = r_i + 4'd1;
                if (i_end) n_state = StIdle;
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_i <= '0;
            r_j <= '0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_i <= n_i;
            r_j <= n_j;
            r_cnt <= n_cnt;
        end
    end
endmodule

>>> hw/rtl/ball_motion_collision_step_core.sv
// Top level of the ball motion and collision step core.
// A write command gives no result and leaves busy low.
// A step with N balls loads, compares (one pair compare per cycle), resolves and bounces each ball in turn,
// then emits the N entries in index order; each result is registered from the emit state.
// Busy is high while the step runs, through the last emit; the next command can be taken as the last result shows.
// Results come one per cycle and the receiver cannot stall; reset clears control, not the table.
module ball_motion_collision_step_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [bmcs_pkg::FieldW-1:0]         i_cfg_data,
    input  logic                                i_command,
    input  logic [bmcs_pkg::IdxW-1:0]           i_ball_index,
    input  logic signed [bmcs_pkg::PosW-1:0]    i_pos_x,
    input  logic signed [bmcs_pkg::PosW-1:0]    i_pos_y,
    input  logic signed [bmcs_pkg::PosW-1:0]    i_vel_x,
    input  logic signed [bmcs_pkg::PosW-1:0]    i_vel_y,
    input  logic [bmcs_pkg::RadW-1:0]           i_radius,
    output logic                                o_valid,
    output logic [bmcs_pkg::IdxW-1:0]           o_ball_index_res,
    output logic signed [bmcs_pkg::PosW-1:0]    o_pos_x_res,
    output logic signed [bmcs_pkg::PosW-1:0]    o_pos_y_res,
    output logic signed [bmcs_pkg::PosW-1:0]    o_vel_x_res,
    output logic signed [bmcs_pkg::PosW-1:0]    o_vel_y_res,
    output logic                                o_last
);
    logic [bmcs_pkg::CntW-1:0]   r_ball_count;
    logic [bmcs_pkg::FieldW-1:0] r_field_width, r_field_height;
    bmcs_pkg::t_dp_cmd           cmd;
    bmcs_pkg::t_dp_sts           sts;
    logic                        ctl_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ball_count   <= 5'd1;
            r_field_width  <= 15'd10240;
            r_field_height <= 15'd7680;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bmcs_pkg::CfgBallCount:   r_ball_count   <= i_cfg_data[bmcs_pkg::CntW-1:0];
                bmcs_pkg::CfgFieldWidth:  r_field_width  <= i_cfg_data;
                bmcs_pkg::CfgFieldHeight: r_field_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The hit status is consumed inside the datapath; busy covers all sequencing.
    assign busy = ctl_busy | (sts.hit & 1'b0);

    bmcs_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_command),
        .i_count   (r_ball_count),
        .o_busy    (ctl_busy),
        .o_cmd     (cmd)
    );

    bmcs_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_ball_index     (i_ball_index),
        .i_pos_x          (i_pos_x),
        .i_pos_y          (i_pos_y),
        .i_vel_x          (i_vel_x),
        .i_vel_y          (i_vel_y),
        .i_radius         (i_radius),
        .i_field_width    (r_field_width),
        .i_field_height   (r_field_height),
        .o_valid          (o_valid),
        .o_ball_index_res (o_ball_index_res),
        .o_pos_x_res      (o_pos_x_res),
        .o_pos_y_res      (o_pos_y_res),
        .o_vel_x_res      (o_vel_x_res),
        .o_vel_y_res      (o_vel_y_res),
        .o_last           (o_last)
    );
endmodule

>>> hw/rtl/bmcs_checker.sv
// Port-level checks for the ball core, bound to the top level.
module bmcs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_command,
    input logic o_valid,
    input logic o_last
);
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without valid");
    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_command) |=> !busy) else $error("write made busy");
    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !$past(busy)) |-> !o_valid) else $error("result while idle");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy) else $error("busy after last result");
endmodule

bind ball_motion_collision_step_core bmcs_checker u_bmcs_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .o_valid   (o_valid),
    .o_last    (o_last)
);
